// ===== sv/awvc_pkg.sv =====
// ----------------------------------------------------------------------------
// awvc_pkg
// Shared widths, register map, class codes, configuration bundle and the
// sequencer state type of the window variance activity classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package awvc_pkg;

    // Field and datapath widths fixed by the sample format.
    localparam int AXIS_W    = 12;   // one signed axis sample
    localparam int MAG_W     = 12;   // magnitude, at most 3547 mg
    localparam int RAD_W     = 24;   // x^2 + y^2 + z^2
    localparam int VAR_W     = 24;   // variance limits, mg^2
    localparam int LVL_W     = 11;   // mean level and tolerance, mg
    localparam int MAG_MAX   = 4095; // largest value a magnitude entry can hold

    // Stream payload widths.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 8;
    localparam int CLASS_W   = 2;

    // APB register port.
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int IDX_W     = 3;

    // Register indexes (byte address divided by four).
    localparam logic [IDX_W-1:0] REG_SLEEP_VAR = 3'd0;
    localparam logic [IDX_W-1:0] REG_STILL_VAR = 3'd1;
    localparam logic [IDX_W-1:0] REG_WALK_VAR  = 3'd2;
    localparam logic [IDX_W-1:0] REG_ONE_G     = 3'd3;
    localparam logic [IDX_W-1:0] REG_MEAN_TOL  = 3'd4;

    // Register reset values.
    localparam logic [VAR_W-1:0] RST_SLEEP_VAR = 24'd1000;
    localparam logic [VAR_W-1:0] RST_STILL_VAR = 24'd10000;
    localparam logic [VAR_W-1:0] RST_WALK_VAR  = 24'd50000;
    localparam logic [LVL_W-1:0] RST_ONE_G     = 11'd1000;
    localparam logic [LVL_W-1:0] RST_MEAN_TOL  = 11'd100;

    // Activity class codes.
    localparam logic [CLASS_W-1:0] CLASS_STILL    = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_WALKING  = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_RUNNING  = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_SLEEPING = 2'd3;

    // Configuration values handed from the register file to the datapath.
    typedef struct packed {
        logic [VAR_W-1:0] sleep_var_limit;
        logic [VAR_W-1:0] still_var_limit;
        logic [VAR_W-1:0] walk_var_limit;
        logic [LVL_W-1:0] one_g_level;
        logic [LVL_W-1:0] mean_tolerance;
    } awvc_cfg_t;

    // Sequencer states of the per-sample pass.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SQUARE,
        ST_ROOT_GO,
        ST_ROOT,
        ST_OLD_SQ,
        ST_NEW_SQ,
        ST_SUMS,
        ST_SPREAD,
        ST_DEVIATE,
        ST_DECIDE
    } awvc_state_t;

endpackage

`default_nettype wire

// ===== sv/accel_window_variance_classifier_core.sv =====
// ----------------------------------------------------------------------------
// accel_window_variance_classifier_core
// Classifies activity from the variance and mean of the accelerometer
// magnitude over a sliding window of WINDOW_LEN samples.
//
// Samples arrive on the s_ stream (x, y, z in milli-g); one class code per
// sample leaves on the m_ stream: still, walking, running or sleeping.
// The magnitude ring sits in a RAM; running sum and sum of squares are kept
// in registers and updated by read-modify-write of the replaced entry.
// Limits and the mean window are to be set over the APB port only while
// idle; the block itself does not enforce this. A new sample is taken only
// once the last one is decided; the 12-step square root sequence and the
// single shared squarer set the sample rate.
// A finished result waits in the output register, and the next sample is
// taken while it waits; a stalled receiver holds the block only once a
// second result is ready to be loaded.
// Reset clears the sums, the write pointer and the per-entry valid bits, so
// the ring reads as zeros; registers return to their default limits.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_window_variance_classifier_core #(
    parameter int WINDOW_LEN = 32
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // Sample stream.
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // s_tdata: accel_x [11:0], accel_y [23:12], accel_z [35:24], zero [39:36]
    input  wire logic [awvc_pkg::S_TDATA_W-1:0]   s_tdata,
    // Class stream.
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // m_tdata: activity_class [1:0], zero [7:2]
    output logic      [awvc_pkg::M_TDATA_W-1:0]   m_tdata,
    // Register port.
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [awvc_pkg::APB_AW-1:0]      paddr,
    input  wire logic [awvc_pkg::APB_DW-1:0]      pwdata,
    output logic      [awvc_pkg::APB_DW-1:0]      prdata,
    output logic                                  pready
);

    import awvc_pkg::*;

    localparam int LW = $clog2(WINDOW_LEN);
    localparam int SW = MAG_W + LW;    // window sum
    localparam int QW = RAD_W + LW;    // window sum of squares
    localparam int CW = 2 * SW;        // N*Q, S*S and scaled limits
    localparam logic [CW-1:0] N_C     = CW'(WINDOW_LEN);
    localparam logic [CW-1:0] N_SQ    = CW'(WINDOW_LEN * WINDOW_LEN);
    localparam logic [SW-1:0] N_S     = SW'(WINDOW_LEN);
    localparam logic [SW-1:0] SUM_MAX = SW'(WINDOW_LEN * MAG_MAX);
    localparam logic [LW-1:0] PTR_LAST = LW'(WINDOW_LEN - 1);
    localparam logic [1:0]    AXIS_LAST = 2'd2;

    awvc_cfg_t   cfg;
    awvc_state_t state_reg, state_next;

    logic                  accept;
    logic                  out_free;
    logic                  out_load;
    logic                  sq_start;
    logic                  sq_done;
    logic [MAG_W-1:0]      sq_root;
    logic                  ram_we;
    logic [MAG_W-1:0]      ram_rdata;
    logic [MAG_W-1:0]      old_val;

    logic [1:0]            axis_cnt_reg;
    logic [LW-1:0]         ptr_reg;
    logic [WINDOW_LEN-1:0] valid_reg;
    logic [SW-1:0]         sum_reg;
    logic [QW-1:0]         sq_reg;
    logic                  m_tvalid_reg;
    logic [CLASS_W-1:0]    class_reg;

    logic [AXIS_W-1:0]     ax_reg, ay_reg, az_reg;
    logic [AXIS_W-1:0]     ax_abs, ay_abs, az_abs;
    logic [AXIS_W-1:0]     axis_sel;
    logic [RAD_W-1:0]      rad_reg;
    logic [MAG_W-1:0]      mag_reg;
    logic [MAG_W-1:0]      old_reg;
    logic [RAD_W-1:0]      old_sq_reg;
    logic [RAD_W-1:0]      new_sq_reg;
    logic [CW-1:0]         nq_reg;
    logic [CW-1:0]         ss_reg;
    logic [CW-1:0]         spread_reg;
    logic [SW-1:0]         dev_reg;

    logic [SW-1:0]         sq_in;
    logic [CW-1:0]         sq_out;
    logic [SW-1:0]         target;
    logic [CLASS_W-1:0]    class_next;

    // ------------------------------------------------------------------
    // Register file and square root unit.
    // ------------------------------------------------------------------
    awvc_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    awvc_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sq_start),
        .radicand (rad_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Magnitude ring; the read address follows the write pointer.
    awvc_ram #(
        .WIDTH (MAG_W),
        .DEPTH (WINDOW_LEN)
    ) u_ring (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (mag_reg),
        .raddr (ptr_reg),
        .rdata (ram_rdata)
    );

    // An entry never written since reset reads as zero.
    assign old_val = valid_reg[ptr_reg] ? ram_rdata : '0;

    // Absolute values of the three axes.
    assign ax_abs = s_tdata[AXIS_W-1] ? (~s_tdata[AXIS_W-1:0] + 1'b1)
                                      : s_tdata[AXIS_W-1:0];
    assign ay_abs = s_tdata[2*AXIS_W-1] ? (~s_tdata[2*AXIS_W-1:AXIS_W] + 1'b1)
                                        : s_tdata[2*AXIS_W-1:AXIS_W];
    assign az_abs = s_tdata[3*AXIS_W-1] ? (~s_tdata[3*AXIS_W-1:2*AXIS_W] + 1'b1)
                                        : s_tdata[3*AXIS_W-1:2*AXIS_W];

    always_comb begin
        unique case (axis_cnt_reg)
            2'd0:    axis_sel = ax_reg;
            2'd1:    axis_sel = ay_reg;
            default: axis_sel = az_reg;
        endcase
    end

    // Shared squarer: axes, old and new magnitude, then the window sum.
    always_comb begin
        unique case (state_reg)
            ST_SQUARE: sq_in = SW'(axis_sel);
            ST_OLD_SQ: sq_in = SW'(old_val);
            ST_NEW_SQ: sq_in = SW'(mag_reg);
            ST_SPREAD: sq_in = sum_reg;
            default:   sq_in = '0;
        endcase
    end
    assign sq_out = CW'(sq_in) * CW'(sq_in);

    assign target   = SW'(cfg.one_g_level) * N_S;
    assign out_free = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Class decision from the scaled variance and mean deviation.
    always_comb begin
        priority if (spread_reg < CW'(cfg.sleep_var_limit) * N_SQ &&
                     dev_reg < SW'(cfg.mean_tolerance) * N_S) begin
            class_next = CLASS_SLEEPING;
        end else if (spread_reg < CW'(cfg.still_var_limit) * N_SQ) begin
            class_next = CLASS_STILL;
        end else if (spread_reg < CW'(cfg.walk_var_limit) * N_SQ) begin
            class_next = CLASS_WALKING;
        end else begin
            class_next = CLASS_RUNNING;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer: next state and control strobes.
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        sq_start   = 1'b0;
        ram_we     = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    state_next = ST_SQUARE;
                end
            end
            ST_SQUARE: begin
                if (axis_cnt_reg == AXIS_LAST) begin
                    state_next = ST_ROOT_GO;
                end
            end
            ST_ROOT_GO: begin
                sq_start   = 1'b1;
                state_next = ST_ROOT;
            end
            ST_ROOT: begin
                if (sq_done) begin
                    state_next = ST_OLD_SQ;
                end
            end
            ST_OLD_SQ: state_next = ST_NEW_SQ;
            ST_NEW_SQ: begin
                ram_we     = 1'b1;
                state_next = ST_SUMS;
            end
            ST_SUMS:    state_next = ST_SPREAD;
            ST_SPREAD:  state_next = ST_DEVIATE;
            ST_DEVIATE: state_next = ST_DECIDE;
            ST_DECIDE: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state, window sums, pointer and valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            axis_cnt_reg <= '0;
            ptr_reg      <= '0;
            valid_reg    <= '0;
            sum_reg      <= '0;
            sq_reg       <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                axis_cnt_reg <= '0;
            end else if (state_reg == ST_SQUARE) begin
                axis_cnt_reg <= axis_cnt_reg + 2'd1;
            end
            if (ram_we) begin
                valid_reg[ptr_reg] <= 1'b1;
            end
            if (state_reg == ST_SUMS) begin
                sum_reg <= sum_reg - SW'(old_reg) + SW'(mag_reg);
                sq_reg  <= sq_reg - QW'(old_sq_reg) + QW'(new_sq_reg);
                ptr_reg <= (ptr_reg == PTR_LAST) ? '0 : ptr_reg + 1'b1;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ax_reg  <= ax_abs;
            ay_reg  <= ay_abs;
            az_reg  <= az_abs;
            rad_reg <= '0;
        end
        unique case (state_reg)
            ST_SQUARE: rad_reg <= rad_reg + sq_out[RAD_W-1:0];
            ST_ROOT: begin
                if (sq_done) begin
                    mag_reg <= sq_root;
                end
            end
            ST_OLD_SQ: begin
                old_reg    <= old_val;
                old_sq_reg <= sq_out[RAD_W-1:0];
            end
            ST_NEW_SQ: new_sq_reg <= sq_out[RAD_W-1:0];
            ST_SPREAD: begin
                ss_reg <= sq_out;
                nq_reg <= CW'(sq_reg) * N_C;
            end
            ST_DEVIATE: begin
                spread_reg <= (nq_reg >= ss_reg) ? nq_reg - ss_reg : '0;
                dev_reg    <= (sum_reg >= target) ? sum_reg - target
                                                  : target - sum_reg;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            class_reg <= class_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(class_reg);

`ifndef ASSERT_OFF
    // The root unit reports completion only while the sequencer waits for it.
    a_root_done_in_wait : assert property (@(posedge aclk) disable iff (!aresetn)
        sq_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside the wait state");

    // The window sum never exceeds a full window of largest magnitudes.
    a_sum_bounded : assert property (@(posedge aclk) disable iff (!aresetn)
        sum_reg <= SUM_MAX)
        else $error("window sum out of range");

    // A decision with room in the output register becomes a result request.
    a_decide_delivers : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DECIDE && out_free) |=> (state_reg == ST_IDLE && m_tvalid))
        else $error("decided class not presented");
`endif

endmodule

`default_nettype wire

// ===== sv/awvc_ram.sv =====
// ----------------------------------------------------------------------------
// awvc_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module awvc_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== sv/awvc_sqrt.sv =====
// ----------------------------------------------------------------------------
// awvc_sqrt
// Iterative floor square root of a 24-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module awvc_sqrt (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [awvc_pkg::RAD_W-1:0]  radicand,
    output logic                             done,
    output logic      [awvc_pkg::MAG_W-1:0]  root
);

    import awvc_pkg::*;

    localparam logic [RAD_W-1:0] BIT_INIT = RAD_W'(1) << (RAD_W - 2);

    logic [RAD_W-1:0] bit_reg;
    logic             done_reg;
    logic [RAD_W-1:0] rem_reg;
    logic [RAD_W-1:0] root_reg;
    logic [RAD_W:0]   trial;
    logic             fits;

    // Trial subtrahend for the current result bit.
    assign trial = {1'b0, root_reg} + {1'b0, bit_reg};
    assign fits  = ({1'b0, rem_reg} >= trial);

    // Step control: the weight walks down two bit places each cycle.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                bit_reg <= BIT_INIT;
            end else if (bit_reg != '0) begin
                bit_reg <= bit_reg >> 2;
                if (bit_reg[0]) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Remainder and partial root.
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= radicand;
            root_reg <= '0;
        end else if (bit_reg != '0) begin
            if (fits) begin
                rem_reg  <= rem_reg - trial[RAD_W-1:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg[MAG_W-1:0];

endmodule

`default_nettype wire

// ===== sv/awvc_cfg.sv =====
// ----------------------------------------------------------------------------
// awvc_cfg
// APB register file holding the variance limits and the mean window.
// ----------------------------------------------------------------------------
`default_nettype none

module awvc_cfg (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [awvc_pkg::APB_AW-1:0]  paddr,
    input  wire logic [awvc_pkg::APB_DW-1:0]  pwdata,
    output logic      [awvc_pkg::APB_DW-1:0]  prdata,
    output logic                              pready,
    output awvc_pkg::awvc_cfg_t               cfg
);

    import awvc_pkg::*;

    awvc_cfg_t        cfg_reg;
    logic [IDX_W-1:0] idx;
    logic             wr_en;

    assign idx    = paddr[APB_AW-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes; excess data bits are dropped, unknown indexes ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sleep_var_limit <= RST_SLEEP_VAR;
            cfg_reg.still_var_limit <= RST_STILL_VAR;
            cfg_reg.walk_var_limit  <= RST_WALK_VAR;
            cfg_reg.one_g_level     <= RST_ONE_G;
            cfg_reg.mean_tolerance  <= RST_MEAN_TOL;
        end else if (wr_en) begin
            unique case (idx)
                REG_SLEEP_VAR: cfg_reg.sleep_var_limit <= pwdata[VAR_W-1:0];
                REG_STILL_VAR: cfg_reg.still_var_limit <= pwdata[VAR_W-1:0];
                REG_WALK_VAR:  cfg_reg.walk_var_limit  <= pwdata[VAR_W-1:0];
                REG_ONE_G:     cfg_reg.one_g_level     <= pwdata[LVL_W-1:0];
                REG_MEAN_TOL:  cfg_reg.mean_tolerance  <= pwdata[LVL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Read back.
    always_comb begin
        unique case (idx)
            REG_SLEEP_VAR: prdata = APB_DW'(cfg_reg.sleep_var_limit);
            REG_STILL_VAR: prdata = APB_DW'(cfg_reg.still_var_limit);
            REG_WALK_VAR:  prdata = APB_DW'(cfg_reg.walk_var_limit);
            REG_ONE_G:     prdata = APB_DW'(cfg_reg.one_g_level);
            REG_MEAN_TOL:  prdata = APB_DW'(cfg_reg.mean_tolerance);
            default:       prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== tb/tb_accel_window_variance_classifier_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_accel_window_variance_classifier_core
// Self-checking bench for the window variance activity classifier.
//
// Accelerometer requests are streamed into the core while a local copy of the
// magnitude window, the running sums and the register limits predicts the
// class of every request. Each class leaving the core is compared with the
// oldest prediction. Limits are reprogrammed over APB between phases, and
// read back. Both stream sides idle at random, and the result side is held
// off for a long stretch once so that the core backs up onto its input.
// ----------------------------------------------------------------------------
module tb_accel_window_variance_classifier_core;
    import awvc_pkg::*;

    localparam int              WIN          = 32;
    localparam longint unsigned WIN_L        = 64'd32;
    localparam int              MAG_PEAK     = 3547;
    localparam int              HOLD_CYCLES  = 400;
    localparam int              DRAIN_CYCLES = 30;

    // One request, accel_x in the lowest bits.
    typedef struct packed {
        logic signed [AXIS_W-1:0] z;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] x;
    } sample_t;

    // Local copy of the programmed limits.
    typedef struct packed {
        logic [VAR_W-1:0] doze_var;
        logic [VAR_W-1:0] calm_var;
        logic [VAR_W-1:0] stride_var;
        logic [LVL_W-1:0] rest_level;
        logic [LVL_W-1:0] rest_tol;
    } limits_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_AW-1:0]      paddr    = '0;
    logic [APB_DW-1:0]      pwdata   = '0;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    // Predictor state: window contents, write slot and running sums.
    limits_t                lim;
    logic [MAG_W-1:0]       mag_ring [WIN];
    int unsigned            ring_pos;
    longint unsigned        run_sum;
    longint unsigned        run_sq;

    sample_t                pending_samples [$];
    logic [CLASS_W-1:0]     pending_class [$];

    sample_t                tx_item;
    bit                     tx_busy;
    bit                     tx_taken;
    bit                     idle_on;
    int unsigned            tx_gap;
    int unsigned            rx_gap;
    int unsigned            hold_left;
    int unsigned            hold_req;
    int unsigned            hold_ack;
    int                     fail_count;
    int                     accepted;
    int                     delivered;
    int                     settings;
    int                     class_tally [4];

    accel_window_variance_classifier_core #(
        .WINDOW_LEN (WIN)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Floor square root, one result bit per step from the top.
    function automatic int unsigned root_floor(input int unsigned v);
        int unsigned r;
        int unsigned t;
        r = 0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            t = r | (1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic int unsigned axis_size(input logic [AXIS_W-1:0] a);
        int v;
        v = $signed(a);
        return (v < 0) ? -v : v;
    endfunction

    // Slide the window by one magnitude and classify the new window.
    function automatic logic [CLASS_W-1:0] predict_class(input sample_t s);
        int unsigned     ax, ay, az, mag, old;
        longint unsigned spread, sq, centre, offs;
        ax  = axis_size(s.x);
        ay  = axis_size(s.y);
        az  = axis_size(s.z);
        mag = root_floor(ax * ax + ay * ay + az * az);
        old = mag_ring[ring_pos];
        run_sum = run_sum + mag - old;
        run_sq  = run_sq + 64'(mag) * 64'(mag) - 64'(old) * 64'(old);
        mag_ring[ring_pos] = MAG_W'(mag);
        ring_pos = (ring_pos + 1) % WIN;

        spread = WIN_L * run_sq;
        sq     = run_sum * run_sum;
        spread = (spread >= sq) ? spread - sq : 64'd0;
        centre = WIN_L * lim.rest_level;
        offs   = (run_sum >= centre) ? run_sum - centre : centre - run_sum;

        if (spread < WIN_L * WIN_L * lim.doze_var && offs < WIN_L * lim.rest_tol)
            return CLASS_SLEEPING;
        if (spread < WIN_L * WIN_L * lim.calm_var)
            return CLASS_STILL;
        if (spread < WIN_L * WIN_L * lim.stride_var)
            return CLASS_WALKING;
        return CLASS_RUNNING;
    endfunction

    function automatic sample_t make_sample(input int x, input int y, input int z);
        sample_t s;
        s.x = AXIS_W'(x);
        s.y = AXIS_W'(y);
        s.z = AXIS_W'(z);
        return s;
    endfunction

    // A sample whose magnitude is close to the goal, in a random orientation.
    function automatic sample_t shape_sample(input int goal);
        int third, a, b, c;
        third = goal / 3;
        a = int'($urandom_range(0, 2 * third)) - third;
        b = int'($urandom_range(0, 2 * third)) - third;
        c = int'(root_floor(goal * goal - a * a - b * b));
        if (c > 2047) c = 2047;
        if ($urandom_range(0, 1) == 1) c = -c;
        case ($urandom_range(0, 2))
            0:       return make_sample(a, b, c);
            1:       return make_sample(c, a, b);
            default: return make_sample(b, c, a);
        endcase
    endfunction

    // Unstructured axis value, biased toward the two full-scale ends.
    function automatic int noise_axis();
        int unsigned r;
        r = $urandom_range(0, 7);
        if (r == 0) return -2048;
        if (r == 1) return 2047;
        return int'($urandom_range(0, 4095)) - 2048;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 45) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(12, 45);
    endfunction

    // Queue runs of rest, walking, running and noise, each long enough to
    // fill most of a window.
    task automatic push_segments(input int unsigned count);
        int unsigned kind, len, n;
        int          g;
        while (count > 0) begin
            kind = $urandom_range(0, 99);
            len  = $urandom_range(20, 70);
            if (len > count) len = count;
            for (n = 0; n < len; n++) begin
                if (kind < 80) begin
                    if (kind < 20)
                        g = int'(lim.rest_level) + int'($urandom_range(0, 40)) - 20;
                    else if (kind < 35)
                        g = int'(lim.rest_level) + int'($urandom_range(0, 2)) - 1;
                    else if (kind < 60)
                        g = 1000 + int'($urandom_range(0, 600)) - 300;
                    else
                        g = int'($urandom_range(100, 3400));
                    if (g < 0) g = 0;
                    if (g > MAG_PEAK) g = MAG_PEAK;
                    pending_samples.push_back(shape_sample(g));
                end else begin
                    pending_samples.push_back(make_sample(noise_axis(), noise_axis(),
                                                          noise_axis()));
                end
            end
            count -= len;
        end
    endtask

    // Hold until every queued request is taken and every class has come back.
    task automatic wait_idle();
        while (pending_samples.size() != 0 || tx_busy || pending_class.size() != 0)
            @(posedge aclk);
    endtask

    task automatic apb_write(input logic [IDX_W-1:0] idx, input logic [APB_DW-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            REG_SLEEP_VAR: lim.doze_var   = value[VAR_W-1:0];
            REG_STILL_VAR: lim.calm_var   = value[VAR_W-1:0];
            REG_WALK_VAR:  lim.stride_var = value[VAR_W-1:0];
            REG_ONE_G:     lim.rest_level = value[LVL_W-1:0];
            REG_MEAN_TOL:  lim.rest_tol   = value[LVL_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Read back every register and compare with the local copy.
    task automatic check_registers();
        logic [APB_DW-1:0] want;
        for (int k = REG_SLEEP_VAR; k <= REG_MEAN_TOL; k++) begin
            case (IDX_W'(k))
                REG_SLEEP_VAR: want = APB_DW'(lim.doze_var);
                REG_STILL_VAR: want = APB_DW'(lim.calm_var);
                REG_WALK_VAR:  want = APB_DW'(lim.stride_var);
                REG_ONE_G:     want = APB_DW'(lim.rest_level);
                default:       want = APB_DW'(lim.rest_tol);
            endcase
            @(negedge aclk);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {IDX_W'(k), 2'b00};
            @(negedge aclk);
            penable <= 1'b1;
            @(posedge aclk);
            while (!pready) @(posedge aclk);
            if (prdata !== want) begin
                $display("%0t: register %0d read mismatch, expected %0h, actual %0h",
                         $time, k, want, prdata);
                fail_count++;
            end
            @(negedge aclk);
            psel    <= 1'b0;
            penable <= 1'b0;
        end
    endtask

    // Program all five limits; bits above each register's width carry junk.
    task automatic program_limits(input logic [APB_DW-1:0] doze, input logic [APB_DW-1:0] calm,
                                  input logic [APB_DW-1:0] stride,
                                  input logic [APB_DW-1:0] level,
                                  input logic [APB_DW-1:0] tol);
        apb_write(REG_SLEEP_VAR, doze   | ($urandom() << VAR_W));
        apb_write(REG_STILL_VAR, calm   | ($urandom() << VAR_W));
        apb_write(REG_WALK_VAR,  stride | ($urandom() << VAR_W));
        apb_write(REG_ONE_G,     level  | ($urandom() << LVL_W));
        apb_write(REG_MEAN_TOL,  tol    | ($urandom() << LVL_W));
        settings++;
    endtask

    // Sample both streams at the rising edge: predict each accepted request
    // and check each delivered class against the oldest prediction.
    always @(posedge aclk) begin : stream_monitor
        logic [CLASS_W-1:0] want;
        if (aresetn && s_tvalid && s_tready) begin
            pending_class.push_back(predict_class(sample_t'(s_tdata[3*AXIS_W-1:0])));
            tx_taken = 1'b1;
            accepted++;
        end
        if (aresetn && m_tvalid && m_tready) begin
            delivered++;
            if (pending_class.size() == 0) begin
                $display("%0t: class result with none expected, expected none, actual %0h",
                         $time, m_tdata);
                fail_count++;
            end else begin
                want = pending_class.pop_front();
                class_tally[want]++;
                if (m_tdata !== {{(M_TDATA_W-CLASS_W){1'b0}}, want}) begin
                    $display("%0t: class mismatch, expected %0h, actual %0h",
                             $time, {{(M_TDATA_W-CLASS_W){1'b0}}, want}, m_tdata);
                    fail_count++;
                end
            end
        end
    end

    // Request driver: one sample at a time from the queue, random gaps.
    always @(negedge aclk) begin : sample_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (tx_busy && tx_taken) begin
                tx_busy = 1'b0;
                tx_gap  = pick_gap();
            end
            tx_taken = 1'b0;
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (pending_samples.size() != 0) begin
                    tx_item = pending_samples.pop_front();
                    tx_busy = 1'b1;
                end
            end
            s_tvalid <= tx_busy;
            s_tdata  <= {{(S_TDATA_W-3*AXIS_W){1'b0}}, tx_item};
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request.
    always @(negedge aclk) begin : class_receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (hold_req != hold_ack) begin
                hold_ack  = hold_req;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < 20) rx_gap = pick_gap();
            end
        end
    end

    initial begin : run_limit
        #(10_000_000);
        $display("%0t: timeout with %0d classes outstanding", $time, pending_class.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin : stimulus
        int unsigned doze, calm, stride, level, tol;
        lim.doze_var   = RST_SLEEP_VAR;
        lim.calm_var   = RST_STILL_VAR;
        lim.stride_var = RST_WALK_VAR;
        lim.rest_level = RST_ONE_G;
        lim.rest_tol   = RST_MEAN_TOL;
        for (int i = 0; i < WIN; i++) mag_ring[i] = '0;
        ring_pos = 0;
        run_sum  = 0;
        run_sq   = 0;
        idle_on  = 1'b1;
        settings = 1;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset limits, then full-scale axes and rest poses while the
        // window still holds the zeros left by reset.
        check_registers();
        pending_samples.push_back(make_sample(0, 0, 0));
        pending_samples.push_back(make_sample(2047, 2047, 2047));
        pending_samples.push_back(make_sample(-2048, -2048, -2048));
        pending_samples.push_back(make_sample(-2048, 2047, -2048));
        pending_samples.push_back(make_sample(2047, -2048, 2047));
        pending_samples.push_back(make_sample(2047, 0, 0));
        pending_samples.push_back(make_sample(-2048, 0, 0));
        pending_samples.push_back(make_sample(0, -2048, 0));
        pending_samples.push_back(make_sample(0, 2047, 0));
        pending_samples.push_back(make_sample(0, 0, -2048));
        pending_samples.push_back(make_sample(0, 0, 2047));
        pending_samples.push_back(make_sample(-1, -1, -1));
        pending_samples.push_back(make_sample(1, 0, 0));
        pending_samples.push_back(make_sample(0, 1, -1));
        pending_samples.push_back(make_sample(0, 0, 1000));
        pending_samples.push_back(make_sample(0, 0, -1000));
        pending_samples.push_back(make_sample(577, 577, 577));
        pending_samples.push_back(make_sample(600, -800, 0));
        pending_samples.push_back(make_sample(-600, 0, 800));
        pending_samples.push_back(make_sample(-1024, 1024, -1024));
        wait_idle();

        // Back-to-back requests while the receiver holds off for a long time.
        idle_on = 1'b0;
        push_segments(400);
        hold_req++;
        wait_idle();
        idle_on = 1'b1;

        // All limits at zero: nothing is below any variance limit.
        program_limits(0, 0, 0, 0, 0);
        check_registers();
        push_segments(120);
        wait_idle();

        // All limits at full scale; writes to unmapped addresses are dropped.
        program_limits('1, '1, '1, '1, '1);
        for (int k = REG_MEAN_TOL + 1; k < (1 << IDX_W); k++)
            apb_write(IDX_W'(k), $urandom());
        check_registers();
        push_segments(150);
        wait_idle();

        // Rest level at zero with the widest tolerance.
        program_limits(20000, 60000, 400000, 0, 2047);
        check_registers();
        push_segments(150);
        wait_idle();

        // Random but ordered limits; one phase runs without idling.
        for (int k = 0; k < 6; k++) begin
            doze   = $urandom_range(0, 30000);
            calm   = doze + $urandom_range(0, 150000);
            stride = calm + $urandom_range(0, 1500000);
            level  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047)
                                                 : $urandom_range(900, 1100);
            tol    = $urandom_range(0, 300);
            program_limits(doze, calm, stride, level, tol);
            check_registers();
            idle_on = (k != 2);
            push_segments(170);
            wait_idle();
        end
        idle_on = 1'b1;

        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Run covered %0d samples and %0d class results over %0d limit settings,",
                 accepted, delivered, settings);
        $display("classes still %0d, walking %0d, running %0d, sleeping %0d, one %0d-cycle hold.",
                 class_tally[CLASS_STILL], class_tally[CLASS_WALKING],
                 class_tally[CLASS_RUNNING], class_tally[CLASS_SLEEPING], HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/awvc_pkg.sv
sv/awvc_ram.sv
sv/awvc_sqrt.sv
sv/awvc_cfg.sv
sv/accel_window_variance_classifier_core.sv
tb/tb_accel_window_variance_classifier_core.sv
